>>> hdl/mcaa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcaa_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the multichannel ADC averager.
// ---------------------------------------------------------------------------
package mcaa_pkg;

  localparam int DEF_CHANNELS = 5;
  localparam int DEF_DEPTH    = 8;

  localparam int SAMPLE_W  = 12;
  localparam int CHANNEL_W = 3;

  // temperature = floor((ofs - avg * slope) / 2^16), clamped at zero
  localparam int                TEMP_OFS_W     = 25;
  localparam int                TEMP_SLOPE_W   = 14;
  localparam int                TEMP_FRAC_W    = 16;
  localparam logic [TEMP_OFS_W-1:0]   TEMP_OFS_Q16   = 25'd23432930;
  localparam logic [TEMP_SLOPE_W-1:0] TEMP_SLOPE_Q16 = 14'd12279;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_AVG,
    ST_TEMP,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic store_wr;
    logic ch_clr;
    logic ch_inc;
    logic chan_start;
    logic rd_issue;
    logic div_mul;
    logic div_take;
    logic temp_mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic wr_end;
    logic row_last;
    logic ch_last;
  } dp_sts_t;

endpackage

>>> hdl/multichannel_adc_averager.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_adc_averager
// Boxcar averager over a circular store of DEPTH rounds by CHANNELS
// samples, with degree conversion of the last (temperature) channel.
// ---------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry in_mode and in_sample. Mode 0 writes
// the sample at the wrapping write pointer. Mode 1 is a readout tick: for
// each channel in order the DEPTH stored samples are read from the store's
// read port one per cycle, summed, divided by DEPTH and, for the last
// channel, converted to degrees; one output word per channel is presented
// on out_valid/out_ready, out_last marking the final one. Each channel
// steps through start, read, accumulate, divide, average, convert, load
// and output, the last step waiting for out_ready. No input word is taken
// while a tick runs; a stalled receiver simply holds the output word and
// the tick. After reset the store is cleared one entry a cycle with
// in_ready low; the write pointer ends at zero.
// ---------------------------------------------------------------------------
module multichannel_adc_averager
  import mcaa_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int DEPTH    = DEF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHANNEL_W-1:0] out_channel,
  output logic [SAMPLE_W-1:0]  out_value,
  output logic                 out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcaa_datapath #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   (in_sample),
    .out_channel (out_channel),
    .out_value   (out_value),
    .out_last    (out_last)
  );

endmodule

>>> hdl/mcaa_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcaa_ctrl
// Sequencer for the averager: store clearing after reset, sample writes,
// and the per-channel read, divide, convert and output steps of a tick.
// ---------------------------------------------------------------------------
module mcaa_ctrl
  import mcaa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.wr_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.ch_clr = 1'b1;
            state_nxt  = ST_START;
          end else begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd.chan_start = 1'b1;
        state_nxt      = ST_READ;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.row_last) begin
          state_nxt = ST_ACC;
        end
      end
      // last read word lands in the accumulator here
      ST_ACC: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_AVG;
      end
      ST_AVG: begin
        cmd.div_take = 1'b1;
        state_nxt    = ST_TEMP;
      end
      ST_TEMP: begin
        cmd.temp_mul = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.ch_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.ch_inc = 1'b1;
            state_nxt  = ST_START;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/mcaa_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcaa_datapath
// Sample store, write pointer, channel accumulator, reciprocal divider and
// temperature conversion, driven step by step from the controller.
// ---------------------------------------------------------------------------
module mcaa_datapath
  import mcaa_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int DEPTH    = DEF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic [CHANNEL_W-1:0] out_channel,
  output logic [SAMPLE_W-1:0]  out_value,
  output logic                 out_last
);

  localparam int StoreSize = CHANNELS * DEPTH;
  localparam int AddrW     = $clog2(StoreSize);
  localparam int ChW       = $clog2(CHANNELS);
  localparam int RowW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AccW      = SAMPLE_W + $clog2(DEPTH);
  // floor(x / DEPTH) = (x * DivMul) >> DivShift, exact for x < 2^AccW
  localparam int DivShift  = AccW + $clog2(DEPTH);
  localparam int MulW      = AccW + 1;
  localparam int ProdW     = AccW + MulW;
  localparam logic [MulW-1:0] DivMul =
    MulW'(((64'd1 << DivShift) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
  localparam int TProdW    = SAMPLE_W + TEMP_SLOPE_W;
  localparam int DegW      = TEMP_OFS_W - TEMP_FRAC_W;

  logic [SAMPLE_W-1:0] mem [StoreSize];

  logic [AddrW-1:0]    wr_ptr_r;
  logic [AddrW-1:0]    rd_addr_r;
  logic [RowW-1:0]     row_cnt_r;
  logic [ChW-1:0]      ch_r;
  logic                rd_vld_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [AccW-1:0]     acc_r;
  logic [ProdW-1:0]    quot_prod_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [TProdW-1:0]   temp_prod_r;
  logic [SAMPLE_W-1:0] out_value_r;

  logic                wr_en;
  logic [TEMP_OFS_W-1:0] temp_diff;
  logic [SAMPLE_W-1:0] temp_deg;

  assign wr_en = cmd.clr_wr | cmd.store_wr;

  assign sts.wr_end   = (wr_ptr_r == AddrW'(StoreSize - 1));
  assign sts.row_last = (row_cnt_r == RowW'(DEPTH - 1));
  assign sts.ch_last  = (ch_r == ChW'(CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= cmd.clr_wr ? '0 : in_sample;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_vld_r <= 1'b0;
      ch_r     <= '0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (wr_en) begin
        wr_ptr_r <= sts.wr_end ? '0 : wr_ptr_r + AddrW'(1);
      end
      if (cmd.ch_clr) begin
        ch_r <= '0;
      end else if (cmd.ch_inc) begin
        ch_r <= ch_r + ChW'(1);
      end
    end
  end

  // entry r * CHANNELS + ch belongs to channel ch
  always_ff @(posedge clk) begin
    if (cmd.chan_start) begin
      rd_addr_r <= AddrW'(ch_r);
      row_cnt_r <= '0;
    end else if (cmd.rd_issue) begin
      rd_addr_r <= rd_addr_r + AddrW'(CHANNELS);
      row_cnt_r <= row_cnt_r + RowW'(1);
    end
    if (cmd.chan_start) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + AccW'(rd_data_r);
    end
    if (cmd.div_mul) begin
      quot_prod_r <= ProdW'(acc_r) * ProdW'(DivMul);
    end
    if (cmd.div_take) begin
      avg_r <= quot_prod_r[DivShift +: SAMPLE_W];
    end
    if (cmd.temp_mul) begin
      temp_prod_r <= TProdW'(avg_r) * TProdW'(TEMP_SLOPE_Q16);
    end
    if (cmd.out_load) begin
      out_value_r <= sts.ch_last ? temp_deg : avg_r;
    end
  end

  // clamp at zero when the product passes the offset
  always_comb begin
    temp_diff = TEMP_OFS_Q16 - TEMP_OFS_W'(temp_prod_r);
    if (temp_prod_r > TProdW'(TEMP_OFS_Q16)) begin
      temp_deg = '0;
    end else begin
      temp_deg = SAMPLE_W'(temp_diff[TEMP_OFS_W-1 -: DegW]);
    end
  end

  assign out_channel = CHANNEL_W'(ch_r);
  assign out_value   = out_value_r;
  assign out_last    = sts.ch_last;

endmodule
